// ===== design/rrtt_pkg.sv =====
// Shared constants for the round-robin thread table: field widths, commands, slot states, status codes.
package rrtt_pkg;

  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;

  // commands
  localparam logic [CMD_W-1:0] CMD_YIELD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EXIT    = 3'd4;

  // per-slot state codes
  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_RUNNING  = 2'd1;
  localparam logic [1:0] ST_RUNNABLE = 2'd2;
  localparam logic [1:0] ST_WAIT     = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_HALTED  = 2'd3;

endpackage

// ===== design/rrtt_req_if.sv =====
// Command channel interface: valid/ready handshake with cmd and target_slot payload.
interface rrtt_req_if import rrtt_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] target_slot;

  modport source (output valid, output cmd, output target_slot, input ready);
  modport sink   (input valid, input cmd, input target_slot, output ready);
endinterface

// ===== design/rrtt_rsp_if.sv =====
// Result channel interface: valid/ready handshake with status, slot_out and switched payload.
interface rrtt_rsp_if import rrtt_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic                switched;

  modport source (output valid, output status, output slot_out, output switched, input ready);
  modport sink   (input valid, input status, input slot_out, input switched, output ready);
endinterface

// ===== design/rrtt_table.sv =====
// Slot state memory: one write port, one registered read port, per-entry valid bits for reset.
module rrtt_table import rrtt_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  localparam int AW = $clog2(NUM_SLOTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [1:0]    rd_data
);

  logic [1:0]           mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] written;
  logic [1:0]           mem_q;
  logic                 written_q;
  logic                 zero_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
      zero_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        // a write to the same entry in this cycle is never paired with a read
        written_q <= written[rd_addr];
        zero_q    <= (rd_addr == '0);
      end
    end
  end

  // untouched entries read as their reset value
  assign rd_data = written_q ? mem_q : (zero_q ? ST_RUNNING : ST_FREE);

endmodule

// ===== design/round_robin_thread_table_top.sv =====
// Round-robin thread slot table: command sequencer around one shared slot-scan unit.
// Throughput: one transaction at a time; the scan reads one table entry per cycle from
// the single read port of the slot memory, which sets the per-command cost.
// Reset (rst, synchronous): slot 0 running, all other slots free, current slot 0, not halted.
module round_robin_thread_table_top import rrtt_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  rrtt_req_if.sink   req,
  rrtt_rsp_if.source rsp
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam logic [AW-1:0] LAST_K = AW'(NUM_SLOTS - 1);

  // one-hot sequencer states
  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CUR_RD  = 9'b000000010,  // read state of current slot
    S_CUR_CHK = 9'b000000100,  // latch it, start yield scan
    S_EXIT    = 9'b000001000,  // free current slot, start yield scan
    S_TGT_RD  = 9'b000010000,  // range check target, read it
    S_TGT_CHK = 9'b000100000,  // act on target state
    S_SCAN    = 9'b001000000,  // pipelined scan, one entry per cycle
    S_FIX     = 9'b010000000,  // demote old slot after a switch
    S_DONE    = 9'b100000000   // hand result to output register
  } state_t;

  state_t              state;
  logic [CMD_W-1:0]    cmd_q;
  logic [SLOT_W-1:0]   tgt_q;
  logic [AW-1:0]       cur;
  logic                halted;
  logic [1:0]          cur_st;     // state of current slot seen by the yield
  logic [AW-1:0]       found;

  // scan unit
  logic                look_free;  // create looks for free, yield for runnable
  logic [AW-1:0]       k;          // offset of next entry to read
  logic                active;     // reads still to issue
  logic                pend;       // read data valid this cycle
  logic [AW-1:0]       pend_addr;
  logic [AW-1:0]       scan_base;
  logic [AW:0]         scan_sum;
  logic [AW-1:0]       scan_addr;
  logic [1:0]          look_st;
  logic                hit;
  logic                scan_end;

  // table ports
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [1:0]          wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [1:0]          rd_data;

  // result staging and output register
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_sw;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_sw;

  logic [AW-1:0]       tgt_idx;
  logic                tgt_ok;
  logic                cur_live;
  logic                tgt_live;

  rrtt_table #(.NUM_SLOTS(NUM_SLOTS)) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // target is valid for suspend/resume only in 1..NUM_SLOTS-1
  assign tgt_idx  = AW'(tgt_q);
  assign tgt_ok   = (tgt_q != '0) && (32'(tgt_q) < 32'(NUM_SLOTS));
  assign cur_live = (cur_st == ST_RUNNING) || (cur_st == ST_RUNNABLE);
  assign tgt_live = (rd_data == ST_RUNNING) || (rd_data == ST_RUNNABLE);

  // scan address: base + k modulo NUM_SLOTS, k in 1..NUM_SLOTS-1
  assign scan_base = look_free ? '0 : cur;
  assign scan_sum  = {1'b0, scan_base} + {1'b0, k};
  assign scan_addr = (scan_sum >= (AW+1)'(NUM_SLOTS)) ?
                     AW'(scan_sum - (AW+1)'(NUM_SLOTS)) : AW'(scan_sum);
  assign look_st   = look_free ? ST_FREE : ST_RUNNABLE;
  assign hit       = pend && (rd_data == look_st);
  assign scan_end  = !pend && !active;

  // table read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur;
    case (state)
      S_CUR_RD: begin
        rd_en = 1'b1;
      end
      S_TGT_RD: begin
        rd_en   = tgt_ok;
        rd_addr = tgt_idx;
      end
      S_SCAN: begin
        rd_en   = active && !hit;
        rd_addr = scan_addr;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = ST_FREE;
    case (state)
      S_EXIT: begin
        wr_en = 1'b1;
      end
      S_TGT_CHK: begin
        wr_addr = tgt_idx;
        if (cmd_q == CMD_SUSPEND) begin
          wr_en   = tgt_live;
          wr_data = ST_WAIT;
        end else begin
          wr_en   = (rd_data == ST_WAIT);
          wr_data = ST_RUNNABLE;
        end
      end
      S_SCAN: begin
        if (hit) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr;
          wr_data = look_free ? ST_RUNNABLE : ST_RUNNING;
        end else if (scan_end && !look_free) begin
          // nothing else runnable: current slot keeps running if it can
          wr_en   = cur_live;
          wr_data = ST_RUNNING;
        end
      end
      S_FIX: begin
        wr_en   = cur_live;
        wr_data = ST_RUNNABLE;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.slot_out = out_slot;
  assign rsp.switched = out_sw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      active    <= 1'b0;
    end else begin
      pend      <= (state == S_SCAN) && active && !hit;
      pend_addr <= scan_addr;
      // output register loads from S_DONE, otherwise clears once taken
      if ((state == S_DONE) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q    <= req.cmd;
            tgt_q    <= req.target_slot;
            res_slot <= SLOT_W'(cur);
            res_sw   <= 1'b0;
            if (halted) begin
              res_status <= STAT_HALTED;
              state      <= S_DONE;
            end else begin
              case (req.cmd)
                CMD_YIELD: begin
                  res_status <= STAT_DONE;
                  state      <= S_CUR_RD;
                end
                CMD_CREATE: begin
                  res_status <= STAT_DONE;
                  look_free  <= 1'b1;
                  k          <= AW'(1);
                  active     <= 1'b1;
                  state      <= S_SCAN;
                end
                CMD_SUSPEND, CMD_RESUME: begin
                  res_status <= STAT_DONE;
                  state      <= S_TGT_RD;
                end
                CMD_EXIT: begin
                  res_status <= STAT_DONE;
                  state      <= S_EXIT;
                end
                default: begin
                  res_status <= STAT_BAD;
                  state      <= S_DONE;
                end
              endcase
            end
          end
        end

        S_CUR_RD: begin
          state <= S_CUR_CHK;
        end

        S_CUR_CHK: begin
          cur_st    <= rd_data;
          look_free <= 1'b0;
          k         <= AW'(1);
          active    <= 1'b1;
          state     <= S_SCAN;
        end

        S_EXIT: begin
          cur_st    <= ST_FREE;
          look_free <= 1'b0;
          k         <= AW'(1);
          active    <= 1'b1;
          state     <= S_SCAN;
        end

        S_TGT_RD: begin
          if (tgt_ok) begin
            state <= S_TGT_CHK;
          end else begin
            res_status <= STAT_BAD;
            state      <= S_DONE;
          end
        end

        S_TGT_CHK: begin
          if ((cmd_q == CMD_SUSPEND) && tgt_live && (tgt_idx == cur)) begin
            // suspending the running slot hands off like a yield
            cur_st    <= ST_WAIT;
            look_free <= 1'b0;
            k         <= AW'(1);
            active    <= 1'b1;
            state     <= S_SCAN;
          end else begin
            state <= S_DONE;
            if (cmd_q == CMD_SUSPEND) begin
              if (!tgt_live) begin
                res_status <= STAT_BAD;
              end
            end else if (rd_data != ST_WAIT) begin
              res_status <= STAT_BAD;
            end
          end
        end

        S_SCAN: begin
          if (active) begin
            k <= k + AW'(1);
            if (k == LAST_K) begin
              active <= 1'b0;
            end
          end
          if (hit) begin
            res_slot <= SLOT_W'(pend_addr);
            if (look_free) begin
              state <= S_DONE;
            end else begin
              found  <= pend_addr;
              res_sw <= 1'b1;
              state  <= S_FIX;
            end
          end else if (scan_end) begin
            state <= S_DONE;
            if (look_free) begin
              res_status <= STAT_NO_FREE;
            end else if (!cur_live) begin
              halted     <= 1'b1;
              res_status <= STAT_HALTED;
            end
          end
        end

        S_FIX: begin
          cur   <= found;
          state <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_status <= res_status;
            out_slot   <= res_slot;
            out_sw     <= res_sw;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
